[hdl/bks_pkg.sv]
// Shared types and constants for the bicycle kinematics pose stepper.
`timescale 1ns / 1ps
package bks_pkg;

  // Number of entries in the arctangent table of the CORDIC unit.
  localparam int ATAN_N = 24;
  localparam int ATAN_IW = 5;

  // CORDIC start vector 0.607252935 in Q2.30.
  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;
  // 2^32 / (2*pi), turns radians into binary angle.
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

  // arctan(2^-i) as a binary angle where 2^32 is a full turn.
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10431, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Configuration register indexes.
  localparam logic [2:0] CFG_STEP_TIME = 3'd0;
  localparam logic [2:0] CFG_WHEELBASE = 3'd1;
  localparam logic [2:0] CFG_START_X = 3'd2;
  localparam logic [2:0] CFG_START_Y = 3'd3;
  localparam logic [2:0] CFG_START_HEADING = 3'd4;

  // Input operation codes.
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_RELOAD = 1'b1;

  // Width of CORDIC vector and angle registers.
  localparam int CW = 34;
  // Divider widths: dividend, divisor, kept quotient bits.
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 50;
  localparam int DIV_QW = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_CORH_GO,
    ST_CORH_W,
    ST_CORS_GO,
    ST_CORS_W,
    ST_MDX,
    ST_MDY,
    ST_MNUM,
    ST_NUMR,
    ST_MMAG,
    ST_MDEN,
    ST_DIVGO,
    ST_DIVW,
    ST_UPD
  } state_t;

endpackage

[hdl/bks_mul.sv]
// Shared 32 by 32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module bks_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

[hdl/bks_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.30.
`timescale 1ns / 1ps
module bks_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  angle,
  output logic                         done,
  output logic signed [bks_pkg::CW-1:0] cos_out,
  output logic signed [bks_pkg::CW-1:0] sin_out
);
  import bks_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  logic signed [CW-1:0] x, y, z;
  logic                 flip;
  logic                 busy;
  logic [IW-1:0]        iter;
  logic [31:0]          rot;
  logic                 need_flip;
  logic signed [CW-1:0] x_sh, y_sh, atan_v;

  // Angles in the left half plane are turned by a half turn first.
  assign rot = angle + 32'h4000_0000;
  assign need_flip = rot[31];
  assign x_sh = x >>> iter;
  assign y_sh = y >>> iter;
  assign atan_v = CW'(ATAN_TAB[ATAN_IW'(iter)]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        if (iter == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= need_flip;
      x <= CW'(CORDIC_GAIN_INV);
      y <= '0;
      z <= CW'(signed'(need_flip ? (angle + 32'h8000_0000) : angle));
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_v;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_v;
      end
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule

[hdl/bks_div.sv]
// Restoring divider, one quotient bit per cycle, keeping the low quotient bits.
`timescale 1ns / 1ps
module bks_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bks_pkg::DIV_NW-1:0]    dividend,
  input  logic [bks_pkg::DIV_DW-1:0]    divisor,
  output logic                          done,
  output logic [bks_pkg::DIV_QW-1:0]    quotient
);
  import bks_pkg::*;

  localparam int KW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW:0]   rem, rem_sh;
  logic              busy;
  logic [KW-1:0]     cnt;
  logic              fits;

  assign rem_sh = {rem[DIV_DW-1:0], num[DIV_NW-1]};
  assign fits = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == KW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[DIV_NW-2:0], 1'b0};
      rem <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
      quotient <= {quotient[DIV_QW-2:0], fits};
    end
  end

endmodule

[hdl/bicycle_kinematics_step.sv]
// Top level of the kinematic bicycle model pose stepper.
`timescale 1ns / 1ps
// The block keeps a vehicle pose (x, y in signed Q16.16 metres, heading as a
// 16-bit binary angle) and advances it by one explicit Euler step of the
// kinematic bicycle model for every accepted input word with op = advance,
// or reloads it from the start registers with op = reload. Every input word
// gives exactly one output word carrying the new pose and a flag telling
// whether x or y was clamped. Work is done one word at a time: in_stall is
// high from acceptance until the result word has been taken. An advance makes
// two passes through the iterative CORDIC unit (heading, then steering angle)
// and uses the restoring divider that forms the heading increment one
// quotient bit per cycle over a 64-bit dividend. All products go through one
// shared 32 by 32 multiplier. A zero wheelbase leaves the heading unchanged;
// a steering cosine at or below zero is taken as one LSB. Positions are held
// with POS_WIDTH bits and saturate. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module bicycle_kinematics_step #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [15:0] speed,
  input  logic signed [14:0] steer,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [15:0]        pose_heading,
  output logic               saturated
);
  import bks_pkg::*;

  // Sum width wide enough for the start values and one step of travel.
  localparam int SW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 2;
  localparam logic signed [SW-1:0] PHI =
    {{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] PLO = ~PHI;

  // Configuration registers.
  logic [15:0]        step_time, wheelbase, start_heading;
  logic signed [31:0] start_x, start_y;

  // Pose state.
  logic signed [POS_WIDTH-1:0] cur_x, cur_y;
  logic [15:0]                 cur_heading;
  logic                        sat;

  state_t state, state_next;

  // Datapath registers.
  logic [15:0]          speed_mag;
  logic                 speed_neg;
  logic [14:0]          steer_q;
  logic [31:0]          dist_mag;
  logic signed [CW-1:0] ch, sh, cs, ss;
  logic signed [SW-1:0] dx, dy;
  logic [31:0]          num_mag;
  logic                 num_neg, num_sgn;
  logic [63:0]          mag;
  logic                 prod_sgn;

  // Shared units.
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_p;
  logic                 cor_start, cor_done;
  logic [31:0]          cor_angle;
  logic signed [CW-1:0] cor_c, cor_s;
  logic                 div_start, div_done;
  logic [DIV_QW-1:0]    div_q;
  logic [DIV_NW-1:0]    div_n;
  logic [DIV_DW-1:0]    div_d;

  logic                 in_acc, out_acc;
  logic signed [64:0]   prod_s, prod_rnd;
  logic signed [SW-1:0] delta;
  logic [31:0]          cs_cl;
  logic [15:0]          dh;
  logic signed [SW-1:0] x_sum, y_sum, x_ext, y_ext;

  function automatic logic [31:0] abs32(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] m;
    m = v[CW-1] ? -v : v;
    return m[31:0];
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] clamp(
    input logic signed [SW-1:0] v
  );
    logic signed [SW-1:0] r;
    r = (v > PHI) ? PHI : ((v < PLO) ? PLO : v);
    return r[POS_WIDTH-1:0];
  endfunction

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE) || out_valid;

  bks_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  bks_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_out (cor_c),
    .sin_out (cor_s)
  );

  bks_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Signed form of the last product and its rounded shift by 38 bits.
  assign prod_s = prod_sgn ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
  assign prod_rnd = prod_s + 65'sd137438953472;
  assign delta = SW'(prod_rnd >>> 38);

  assign cs_cl = (cs < CW'(1)) ? 32'd1 : cs[31:0];
  assign dh = num_neg ? (16'd0 - div_q) : div_q;
  assign x_sum = SW'(cur_x) + dx;
  assign y_sum = SW'(cur_y) + dy;
  assign div_d = {mul_p[DIV_DW-3:0], 2'b00};
  assign div_n = mag + {mul_p[62:0], 1'b0};

  // Sequencer: next state and the operands of the shared units.
  always_comb begin
    mul_a = dist_mag;
    mul_b = 32'd0;
    cor_start = 1'b0;
    cor_angle = {cur_heading, 16'h0000};
    div_start = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && op == OP_ADVANCE) state_next = ST_DIST;
      end
      ST_DIST: begin
        mul_a = {16'h0000, speed_mag};
        mul_b = {16'h0000, step_time};
        state_next = ST_CORH_GO;
      end
      ST_CORH_GO: begin
        cor_start = 1'b1;
        state_next = ST_CORH_W;
      end
      ST_CORH_W: begin
        if (cor_done) state_next = ST_CORS_GO;
      end
      ST_CORS_GO: begin
        cor_start = 1'b1;
        cor_angle = {steer_q[14], steer_q, 16'h0000};
        state_next = ST_CORS_W;
      end
      ST_CORS_W: begin
        if (cor_done) state_next = ST_MDX;
      end
      ST_MDX: begin
        mul_b = abs32(ch);
        state_next = ST_MDY;
      end
      ST_MDY: begin
        mul_b = abs32(sh);
        state_next = ST_MNUM;
      end
      ST_MNUM: begin
        mul_b = abs32(ss);
        state_next = ST_NUMR;
      end
      ST_NUMR: begin
        state_next = ST_MMAG;
      end
      ST_MMAG: begin
        mul_a = num_mag;
        mul_b = INV_TWO_PI_Q32;
        state_next = ST_MDEN;
      end
      ST_MDEN: begin
        mul_a = cs_cl;
        mul_b = {16'h0000, wheelbase};
        state_next = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start = (wheelbase != 16'd0);
        state_next = (wheelbase != 16'd0) ? ST_DIVW : ST_UPD;
      end
      ST_DIVW: begin
        if (div_done) state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= 16'd655;
      wheelbase <= 16'd640;
      start_x <= '0;
      start_y <= '0;
      start_heading <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_TIME: step_time <= cfg_data[15:0];
        CFG_WHEELBASE: wheelbase <= cfg_data[15:0];
        CFG_START_X: start_x <= cfg_data;
        CFG_START_Y: start_y <= cfg_data;
        CFG_START_HEADING: start_heading <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pose state and the output word. The outputs read the pose registers, which
  // only change when a reload word is taken in or an advance reaches ST_UPD.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      cur_heading <= '0;
      sat <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      if (in_acc && op == OP_RELOAD) begin
        cur_x <= clamp(SW'(start_x));
        cur_y <= clamp(SW'(start_y));
        cur_heading <= start_heading;
        sat <= (SW'(start_x) > PHI) || (SW'(start_x) < PLO) ||
               (SW'(start_y) > PHI) || (SW'(start_y) < PLO);
        out_valid <= 1'b1;
      end else if (state == ST_UPD) begin
        cur_x <= clamp(x_sum);
        cur_y <= clamp(y_sum);
        cur_heading <= cur_heading + ((wheelbase != 16'd0) ? dh : 16'd0);
        sat <= (x_sum > PHI) || (x_sum < PLO) || (y_sum > PHI) || (y_sum < PLO);
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath capture, keyed on the sequencer state.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      speed_mag <= speed[15] ? 16'(-speed) : speed;
      speed_neg <= speed[15];
      steer_q <= steer;
    end
    unique case (state)
      ST_CORH_GO: dist_mag <= mul_p[31:0];
      ST_CORH_W: begin
        if (cor_done) begin
          ch <= cor_c;
          sh <= cor_s;
        end
      end
      ST_CORS_W: begin
        if (cor_done) begin
          cs <= cor_c;
          ss <= cor_s;
        end
      end
      ST_MDY: dx <= delta;
      ST_MNUM: dy <= delta;
      ST_NUMR: begin
        // floor of the signed product over 2^30, kept as sign and magnitude
        num_mag <= num_sgn ? 32'((mul_p + 64'h3FFF_FFFF) >> 30) : 32'(mul_p >> 30);
        num_neg <= num_sgn && (mul_p != 64'd0);
      end
      ST_MDEN: mag <= mul_p;
      default: ;
    endcase
  end

  // The sign of each product follows the operands of the previous state.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_MDX: prod_sgn <= speed_neg ^ ch[CW-1];
      ST_MDY: prod_sgn <= speed_neg ^ sh[CW-1];
      default: prod_sgn <= 1'b0;
    endcase
    if (state == ST_MNUM) num_sgn <= speed_neg ^ ss[CW-1];
  end

  assign x_ext = SW'(cur_x);
  assign y_ext = SW'(cur_y);
  assign pose_x = x_ext[31:0];
  assign pose_y = y_ext[31:0];
  assign pose_heading = cur_heading;
  assign saturated = sat;

endmodule

[hdl/bks_checker.sv]
// Port-level checker for the pose stepper and its bind to the top level.
`timescale 1ns / 1ps
module bks_props (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] pose_x,
  input logic signed [31:0] pose_y,
  input logic [15:0]        pose_heading,
  input logic               saturated
);

  // A taken word keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken but block not busy next cycle");

  // No new word is taken while a result word is still waiting.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid)
    else $error("input taken while result pending");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pose_x) && $stable(pose_y)
      && $stable(pose_heading) && $stable(saturated))
    else $error("stalled result word changed");

  // Reset leaves no result word pending.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind bicycle_kinematics_step bks_props u_bks_props (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pose_x       (pose_x),
  .pose_y       (pose_y),
  .pose_heading (pose_heading),
  .saturated    (saturated)
);
